/* hw/rtl/st_pkg.sv */
// Shared types, constants and character helpers of the source tokenizer.
package st_pkg;

    localparam int MAX_TOKEN_LEN = 127;
    localparam int LEN_W         = 7;
    localparam int Q_DEPTH       = 4;
    localparam int Q_AW          = $clog2(Q_DEPTH);
    localparam int Q_CW          = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_COMMENT = 3'd1,
        MODE_WORD    = 3'd2,
        MODE_LT      = 3'd3,
        MODE_GT      = 3'd4,
        MODE_COLON   = 3'd5,
        MODE_MINUS   = 3'd6,
        MODE_PLUS    = 3'd7
    } t_lex_mode;

    typedef struct packed {
        logic [7:0]  tbyte;
        logic        first;
        logic        last;
        logic [15:0] line;
        logic [15:0] column;
    } t_token;

    typedef struct packed {
        logic [1:0] count;
        t_token     tok0;
        t_token     tok1;
    } t_wr;

    function automatic logic is_word_start(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || (c == CH_UNDER);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic is_pair_start(input logic [7:0] c);
        return (c == CH_LT) || (c == CH_GT) || (c == CH_COLON) ||
               (c == CH_MINUS) || (c == CH_PLUS);
    endfunction

    function automatic t_lex_mode mode_of(input logic [7:0] c);
        t_lex_mode m;
        m = MODE_PLUS;
        if (is_word_start(c)) begin
            m = MODE_WORD;
        end else if (c == CH_LT) begin
            m = MODE_LT;
        end else if (c == CH_GT) begin
            m = MODE_GT;
        end else if (c == CH_COLON) begin
            m = MODE_COLON;
        end else if (c == CH_MINUS) begin
            m = MODE_MINUS;
        end
        return m;
    endfunction

    function automatic logic pairs_with(input t_lex_mode m, input logic [7:0] c);
        logic p;
        unique case (m)
            MODE_LT:    p = (c == CH_GT) || (c == CH_EQ) || (c == CH_LT);
            MODE_GT:    p = (c == CH_GT) || (c == CH_EQ);
            MODE_COLON: p = (c == CH_EQ);
            MODE_MINUS: p = (c == CH_GT) || (c == CH_MINUS);
            MODE_PLUS:  p = (c == CH_PLUS);
            default:    p = 1'b0;
        endcase
        return p;
    endfunction

endpackage

/* hw/rtl/st_front.sv */
// Front end: lexer state, character classification and result generation.
module st_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic          i_kind,
    input  logic [7:0]    i_char_code,
    output st_pkg::t_wr   o_wr
);
    import st_pkg::*;

    t_lex_mode        r_mode, n_mode;
    logic [7:0]       r_held_byte, n_held_byte;
    logic             r_held_valid, n_held_valid;
    logic             r_held_first, n_held_first;
    logic [LEN_W-1:0] r_len, n_len;
    logic [15:0]      r_line, n_line;
    logic [15:0]      r_col, n_col;
    logic [15:0]      r_sl, n_sl;
    logic [15:0]      r_sc, n_sc;

    logic [7:0]  c;
    logic        ev_end, ev_flush, ev_pair, ev_start, ev_ext, is_pair_mode;
    logic        w_cont, w_fits;
    logic [15:0] cnt_line, cnt_col;

    assign c            = i_char_code;
    assign is_pair_mode = (r_mode != MODE_IDLE) && (r_mode != MODE_COMMENT) &&
                          (r_mode != MODE_WORD);
    assign w_cont       = is_word_start(c) || (c == CH_DOT);
    assign w_fits       = r_len < LEN_W'(MAX_TOKEN_LEN);
    assign ev_end       = i_kind || (c == 8'd0);
    assign ev_flush     = !ev_end && (((r_mode == MODE_WORD) && !w_cont) ||
                          (is_pair_mode && !pairs_with(r_mode, c)));
    assign ev_pair      = !ev_end && is_pair_mode && pairs_with(r_mode, c);
    assign ev_ext       = !ev_end && (r_mode == MODE_WORD) && w_cont && w_fits;
    assign ev_start     = !ev_end && ((r_mode == MODE_IDLE) || ev_flush);

    always_comb begin
        cnt_line = r_line;
        cnt_col  = (r_col != 16'hFFFF) ? r_col + 16'd1 : r_col;
        if ((c == CH_LF) || (c == CH_CR)) begin
            cnt_col = 16'd0;
        end
        if ((c == CH_LF) && (r_line != 16'hFFFF)) begin
            cnt_line = r_line + 16'd1;
        end
    end

    // Next state of the lexer.
    always_comb begin
        n_mode       = r_mode;
        n_held_byte  = r_held_byte;
        n_held_valid = r_held_valid;
        n_held_first = r_held_first;
        n_len        = r_len;
        n_line       = r_line;
        n_col        = r_col;
        n_sl         = r_sl;
        n_sc         = r_sc;
        if (ev_end) begin
            n_mode       = MODE_IDLE;
            n_held_byte  = 8'd0;
            n_held_valid = 1'b0;
            n_held_first = 1'b0;
            n_len        = '0;
            n_line       = 16'd1;
            n_col        = 16'd0;
            n_sl         = 16'd1;
            n_sc         = 16'd0;
        end else begin
            n_line = cnt_line;
            n_col  = cnt_col;
            if ((r_mode == MODE_COMMENT) && (c == CH_LF)) begin
                n_mode = MODE_IDLE;
            end
            if (ev_ext) begin
                n_held_byte  = to_lower(c);
                n_held_valid = 1'b1;
                n_held_first = 1'b0;
                n_len        = r_len + LEN_W'(1);
            end
            if (ev_flush || ev_pair) begin
                n_mode       = MODE_IDLE;
                n_held_byte  = 8'd0;
                n_held_valid = 1'b0;
                n_held_first = 1'b0;
                n_len        = '0;
            end
            if (ev_start && !is_blank(c)) begin
                if (c == CH_BANG) begin
                    n_mode = MODE_COMMENT;
                end else begin
                    n_sl = cnt_line;
                    n_sc = cnt_col;
                    if (is_word_start(c) || is_pair_start(c)) begin
                        n_held_byte  = to_lower(c);
                        n_held_valid = 1'b1;
                        n_held_first = 1'b1;
                        n_len        = LEN_W'(1);
                        n_mode       = mode_of(c);
                    end else begin
                        n_len = '0;
                    end
                end
            end
        end
    end

    // Result tokens of the accepted byte, in model order.
    always_comb begin
        t_token held_tok;
        t_token new_tok;
        held_tok = '{tbyte: r_held_byte, first: r_held_first, last: 1'b1,
                     line: r_sl, column: r_sc};
        new_tok  = '{tbyte: c, first: 1'b1, last: 1'b1,
                     line: cnt_line, column: cnt_col};
        o_wr       = '0;
        o_wr.tok0  = held_tok;
        o_wr.tok1  = new_tok;
        if (i_accept) begin
            if ((ev_end || ev_flush) && r_held_valid) begin
                o_wr.count = 2'd1;
            end
            if (ev_ext && r_held_valid) begin
                o_wr.tok0.last = 1'b0;
                o_wr.count     = 2'd1;
            end
            if (ev_pair) begin
                o_wr.tok0.last   = 1'b0;
                o_wr.tok1        = '{tbyte: c, first: 1'b0, last: 1'b1,
                                     line: r_sl, column: r_sc};
                o_wr.count       = 2'd2;
            end
            if (ev_start && !is_blank(c) && (c != CH_BANG) &&
                !is_word_start(c) && !is_pair_start(c)) begin
                if (o_wr.count == 2'd0) begin
                    o_wr.tok0 = new_tok;
                end
                o_wr.count = o_wr.count + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_held_valid <= 1'b0;
            r_held_first <= 1'b0;
            r_held_byte  <= 8'd0;
            r_len        <= '0;
            r_line       <= 16'd1;
            r_col        <= 16'd0;
            r_sl         <= 16'd1;
            r_sc         <= 16'd0;
        end else if (i_accept) begin
            r_mode       <= n_mode;
            r_held_valid <= n_held_valid;
            r_held_first <= n_held_first;
            r_held_byte  <= n_held_byte;
            r_len        <= n_len;
            r_line       <= n_line;
            r_col        <= n_col;
            r_sl         <= n_sl;
            r_sc         <= n_sc;
        end
    end

endmodule

/* hw/rtl/st_queue.sv */
// Back end: result queue that takes up to two tokens a cycle and hands out one.
module st_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  st_pkg::t_wr     i_wr,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output st_pkg::t_token  o_tok
);
    import st_pkg::*;

    t_token          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CW-1:0] r_count, n_count;
    logic            pop_ok;

    assign o_empty = (r_count == '0);
    assign o_full  = r_count > Q_CW'(Q_DEPTH - 2);
    assign pop_ok  = i_pop && !o_empty;
    assign o_tok   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr + Q_AW'(i_wr.count);
        n_rd_ptr = r_rd_ptr + Q_AW'(pop_ok);
        n_count  = r_count + Q_CW'(i_wr.count) - Q_CW'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_wr.tok0;
        end
        if (i_wr.count == 2'd2) begin
            r_mem[r_wr_ptr + Q_AW'(1)] <= i_wr.tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

/* hw/rtl/source_tokenizer.sv */
// Top level of the source tokenizer: lexer front end feeding a token queue.
// A token byte is registered into the token queue by the transaction that releases it; word
// bytes and operator-start bytes (< > : - +) are released by the following byte or the end mark.
// Throughput: one input byte per cycle while not full; up to two token bytes each, popped one per cycle.
// The four-entry token queue stops input while three or more token bytes are waiting.
// Reset is synchronous and active low; it empties the queue and restarts at line 1, column 0.
module source_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_kind,
    input  logic [7:0]  i_char_code,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_token_byte,
    output logic        o_token_first,
    output logic        o_token_last,
    output logic [15:0] o_token_line,
    output logic [15:0] o_token_column
);
    import st_pkg::*;

    t_wr    wr;
    t_token tok;
    logic   accept;

    assign accept = push && !full;

    st_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_kind      (i_kind),
        .i_char_code (i_char_code),
        .o_wr        (wr)
    );

    st_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_tok   (tok)
    );

    assign o_token_byte   = tok.tbyte;
    assign o_token_first  = tok.first;
    assign o_token_last   = tok.last;
    assign o_token_line   = tok.line;
    assign o_token_column = tok.column;

endmodule

/* hw/rtl/st_checker.sv */
// Port-level assertions for the source tokenizer and their binding.
module st_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [7:0]  o_token_byte,
    input logic        o_token_first,
    input logic        o_token_last,
    input logic [15:0] o_token_line,
    input logic [15:0] o_token_column
);

    // The queue is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // No result appears without an input transaction.
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        empty && !(push && !full) |=> empty)
        else $error("result appeared without an input transaction");

    // A waiting result holds until it is popped.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_token_byte) && $stable(o_token_first) &&
        $stable(o_token_last) && $stable(o_token_line) && $stable(o_token_column))
        else $error("waiting result changed before pop");

    // Backpressure only arises with results waiting.
    a_full_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !empty)
        else $error("full asserted while result queue is empty");

endmodule

bind source_tokenizer st_checker u_st_checker (.*);
